// ----- sv/hudv_pkg.sv -----
`timescale 1ns / 1ps
package hudv_pkg;

	localparam int CountW   = 15;
	localparam int MaxW     = 14;
	localparam int QDepth   = 4;
	localparam int QAw      = $clog2(QDepth);
	localparam int AccW     = 21;

	localparam logic [MaxW-1:0]   MaxBytesRst = 14'd4096;
	localparam logic [CountW-1:0] CountMax    = 15'h7FFF;

	localparam logic [0:0] RegMaxBytes = 1'b0;

	// one classified character on its way to the UTF-8 checker
	typedef struct packed {
		logic [7:0] data;
		logic       byte_ok;
		logic       last;
		logic       err;
	} hudv_op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} hudv_qstat_t;

endpackage

// ----- sv/hudv_front.sv -----
`timescale 1ns / 1ps
module hudv_front
	import hudv_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      hex_char,
	input  logic            last,
	input  logic [MaxW-1:0] max_bytes,
	output hudv_op_t        op
);

	logic [CountW-1:0] char_count_q;
	logic [3:0]        high_nibble_q;
	logic              high_valid_q;
	logic              odd_phase_q;

	logic [CountW-1:0] count_nx;
	logic [3:0]        nib;
	logic              nib_ok;
	logic              byte_ok;

	always_comb begin
		nib    = 4'd0;
		nib_ok = 1'b0;
		if (hex_char >= 8'h30 && hex_char <= 8'h39) begin
			nib    = hex_char[3:0];
			nib_ok = 1'b1;
		end else if (hex_char >= 8'h61 && hex_char <= 8'h66) begin
			nib    = hex_char[3:0] + 4'd9;
			nib_ok = 1'b1;
		end
	end

	assign count_nx = (char_count_q < CountMax) ? char_count_q + 1'b1 : char_count_q;
	assign byte_ok  = odd_phase_q && high_valid_q && nib_ok;

	always_comb begin
		op.data    = byte_ok ? {high_nibble_q, nib} : 8'h00;
		op.byte_ok = byte_ok;
		op.last    = last;
		op.err     = !nib_ok || (count_nx > {max_bytes, 1'b0}) || (last && !odd_phase_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q  <= '0;
			high_nibble_q <= '0;
			high_valid_q  <= 1'b0;
			odd_phase_q   <= 1'b0;
		end else if (take) begin
			if (last) begin
				char_count_q  <= '0;
				high_nibble_q <= '0;
				high_valid_q  <= 1'b0;
				odd_phase_q   <= 1'b0;
			end else begin
				char_count_q  <= count_nx;
				odd_phase_q   <= !odd_phase_q;
				if (!odd_phase_q) begin
					high_nibble_q <= nib;
					high_valid_q  <= nib_ok;
				end else begin
					high_nibble_q <= '0;
					high_valid_q  <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- sv/hudv_queue.sv -----
`timescale 1ns / 1ps
module hudv_queue
	import hudv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  hudv_op_t    push_op,
	input  logic        pop,
	output hudv_op_t    pop_op,
	output hudv_qstat_t stat
);

	hudv_op_t        mem_q [QDepth];
	logic [QAw-1:0]  wr_ptr_q;
	logic [QAw-1:0]  rd_ptr_q;
	logic [QAw:0]    cnt_q;

	assign pop_op     = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == QAw'(0) + (QAw+1)'(QDepth));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/hudv_back.sv -----
`timescale 1ns / 1ps
module hudv_back
	import hudv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  hudv_op_t   op,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       byte_ready,
	output logic       done_res,
	output logic       accepted
);

	logic [AccW-1:0] acc_q;
	logic [1:0]      pend_q;
	logic [1:0]      len_q;
	logic            err_q;

	logic            valid_q;
	logic [7:0]      data_q;
	logic            ready_q;
	logic            done_q;
	logic            acc_ok_q;

	logic [AccW-1:0] acc_nx;
	logic [AccW-1:0] cp_join;
	logic [1:0]      pend_nx;
	logic [1:0]      len_nx;
	logic            err_nx;
	logic [7:0]      b;

	function automatic logic cp_bad(input logic [AccW-1:0] cp, input logic [1:0] len);
		logic bad;
		bad = 1'b0;
		if (len == 2'd1 && cp < 21'h80)            bad = 1'b1;
		if (len == 2'd2 && cp < 21'h800)           bad = 1'b1;
		if (len == 2'd3 && cp < 21'h10000)         bad = 1'b1;
		if (cp > 21'h10FFFF)                       bad = 1'b1;
		if (cp >= 21'hD800 && cp <= 21'hDFFF)      bad = 1'b1;
		if (cp == '0)                              bad = 1'b1;
		if (cp >= 21'h200B && cp <= 21'h200F)      bad = 1'b1;
		if (cp >= 21'h2028 && cp <= 21'h202E)      bad = 1'b1;
		if (cp >= 21'h2060 && cp <= 21'h206F)      bad = 1'b1;
		if (cp == 21'hFEFF)                        bad = 1'b1;
		return bad;
	endfunction

	assign pop     = !q_empty && (!valid_q || !out_stall);
	assign b       = op.data;
	assign cp_join = {acc_q[AccW-7:0], b[5:0]};

	always_comb begin
		acc_nx  = acc_q;
		pend_nx = pend_q;
		len_nx  = len_q;
		err_nx  = err_q || op.err;
		if (op.byte_ok) begin
			if (pend_q == 2'd0) begin
				if (b < 8'h80) begin
					if (b == 8'h00) err_nx = 1'b1;
				end else if (b >= 8'hC2 && b <= 8'hDF) begin
					acc_nx  = AccW'(b[4:0]);
					pend_nx = 2'd1;
					len_nx  = 2'd1;
				end else if (b >= 8'hE0 && b <= 8'hEF) begin
					acc_nx  = AccW'(b[3:0]);
					pend_nx = 2'd2;
					len_nx  = 2'd2;
				end else if (b >= 8'hF0 && b <= 8'hF4) begin
					acc_nx  = AccW'(b[2:0]);
					pend_nx = 2'd3;
					len_nx  = 2'd3;
				end else begin
					err_nx = 1'b1;
				end
			end else if (b[7:6] != 2'b10) begin
				err_nx  = 1'b1;
				pend_nx = 2'd0;
			end else begin
				acc_nx  = cp_join;
				pend_nx = pend_q - 1'b1;
				if (pend_q == 2'd1 && cp_bad(cp_join, len_q)) err_nx = 1'b1;
			end
		end
		if (op.last && pend_nx != 2'd0) err_nx = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			pend_q  <= '0;
			len_q   <= '0;
			err_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (op.last) begin
					acc_q  <= '0;
					pend_q <= '0;
					len_q  <= '0;
					err_q  <= 1'b0;
				end else begin
					acc_q  <= acc_nx;
					pend_q <= pend_nx;
					len_q  <= len_nx;
					err_q  <= err_nx;
				end
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q   <= op.data;
			ready_q  <= op.byte_ok;
			done_q   <= op.last;
			acc_ok_q <= op.last && !err_nx;
		end
	end

	assign out_valid  = valid_q;
	assign data_byte  = data_q;
	assign byte_ready = ready_q;
	assign done_res   = done_q;
	assign accepted   = acc_ok_q;

endmodule

// ----- sv/hex_utf8_validating_decoder_core.sv -----
`timescale 1ns / 1ps
// Hex string to strict UTF-8 validator. One lower-case hex character is taken per cycle
// while in_stall is low and one result comes out for every character, so the block
// sustains one item per clock when neither side stalls. Each character is decoded into
// a four-entry queue and then checked into the output register that drives out_valid;
// out_stall holds it in the queue. in_stall rises only when the
// queue is full. A completed pair gives data_byte with byte_ready; the character
// marked last carries done_res and the accepted verdict, and clears all string state.
// max_bytes (address 0, reset 4096) bounds the decoded length; 0 rejects all strings.
module hex_utf8_validating_decoder_core
	import hudv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  hex_char,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  data_byte,
	output logic        byte_ready,
	output logic        done_res,
	output logic        accepted
);

	logic [MaxW-1:0] max_bytes_q;
	hudv_op_t        f_op;
	hudv_op_t        b_op;
	hudv_qstat_t     q_stat;
	logic            take;
	logic            pop;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegMaxBytes) ? {{(32-MaxW){1'b0}}, max_bytes_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MaxBytesRst;
		end else if (psel && penable && pwrite && paddr[2] == RegMaxBytes) begin
			max_bytes_q <= pwdata[MaxW-1:0];
		end
	end

	assign in_stall = q_stat.full;
	assign take     = in_valid && !q_stat.full;

	hudv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.hex_char  (hex_char),
		.last      (last),
		.max_bytes (max_bytes_q),
		.op        (f_op)
	);

	hudv_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (take),
		.push_op (f_op),
		.pop     (pop),
		.pop_op  (b_op),
		.stat    (q_stat)
	);

	hudv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_stat.empty),
		.op         (b_op),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_byte  (data_byte),
		.byte_ready (byte_ready),
		.done_res   (done_res),
		.accepted   (accepted)
	);

	a_acc_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> done_res)
		else $error("accepted without done_res");

	a_no_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_ready) |-> (data_byte == 8'h00))
		else $error("data_byte nonzero without byte_ready");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.empty && !out_valid) |=> !out_valid)
		else $error("result without a queued request");

endmodule
